>>> rtl/core/point_rotate_scale_translate_defines.svh
// Assertion macros for the point rotate/scale/translate block.
// Each macro expects a clock named clk and an active-high reset named rst in scope.
`ifndef POINT_ROTATE_SCALE_TRANSLATE_DEFINES_SVH
`define POINT_ROTATE_SCALE_TRANSLATE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PRST_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("prst assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define PRST_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("prst assertion failed");

`endif

>>> rtl/core/prst_pkg.sv
// Shared types, widths, field offsets and trig table builder for the point
// rotate/scale/translate block. No dependencies.
`default_nettype none

package prst_pkg;

  localparam int COORD_BITS      = 16;
  localparam int TRIG_FRAC_BITS  = 14;
  localparam int TRIG_BITS       = TRIG_FRAC_BITS + 2;
  localparam int SCALE_BITS      = 16;
  localparam int SCALE_FRAC_BITS = 8;
  localparam int ANGLE_BITS      = 9;
  localparam int ACTION_BITS     = 3;
  localparam int FULL_TURN       = 360;
  localparam int PI_NUM          = 3142;
  localparam int PI_DEN          = 180000;
  localparam int SERIES_TERMS    = 40;
  // The series angle is d * TRIG_K_STEP / TRIG_DEN radians.
  localparam longint TRIG_K_STEP = PI_NUM / 2;
  localparam longint TRIG_DEN    = PI_DEN / 2;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [TRIG_BITS-1:0]  trig_t;
  typedef logic signed [SCALE_BITS-1:0] scale_t;
  typedef logic        [ANGLE_BITS-1:0] angle_t;
  typedef trig_t trig_table_t [FULL_TURN];

  typedef enum logic [ACTION_BITS-1:0] {
    ACT_LOAD        = 3'd0,
    ACT_TRANSLATE   = 3'd1,
    ACT_ROTATE      = 3'd2,
    ACT_SCALE_RECT  = 3'd3,
    ACT_SCALE_PIVOT = 3'd4
  } action_t;

  // Configuration register indexes.
  localparam int CFG_INDEX_BITS = 1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_ROT_CX = 1'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_ROT_CY = 1'd1;
  localparam coord_t ROT_CX_RESET = coord_t'(375);
  localparam coord_t ROT_CY_RESET = coord_t'(210);

  // Slave-side tdata layout, lowest field first.
  localparam int ARG_X_LSB    = 0;
  localparam int ARG_Y_LSB    = ARG_X_LSB + COORD_BITS;
  localparam int ANGLE_LSB    = ARG_Y_LSB + COORD_BITS;
  localparam int SCALE_LSB    = ANGLE_LSB + ANGLE_BITS;
  localparam int LEFT_LSB     = SCALE_LSB + SCALE_BITS;
  localparam int TOP_LSB      = LEFT_LSB + COORD_BITS;
  localparam int RIGHT_LSB    = TOP_LSB + COORD_BITS;
  localparam int BOTTOM_LSB   = RIGHT_LSB + COORD_BITS;
  localparam int S_FIELD_BITS = BOTTOM_LSB + COORD_BITS;
  localparam int S_DATA_BITS  = ((S_FIELD_BITS + 7) / 8) * 8;
  localparam int M_DATA_BITS  = ((2 * COORD_BITS + 7) / 8) * 8;

  // One transform request as held in the input register.
  typedef struct packed {
    action_t action;
    coord_t  arg_x;
    coord_t  arg_y;
    coord_t  ctr_x;
    coord_t  ctr_y;
    scale_t  scale;
  } xform_op_t;

  // Restoring long division of a non-negative dividend by a positive divisor.
  // Only the table builder uses it, so it is evaluated at elaboration.
  function automatic longint udiv_trunc(input longint num, input longint den);
    longint quo;
    longint rem;
    quo = 0;
    rem = 0;
    for (int b = 62; b >= 0; b--) begin
      rem = (rem << 1) | ((num >>> b) & longint'(1));
      if (rem >= den) begin
        rem = rem - den;
        quo = quo | (longint'(1) << b);
      end
    end
    return quo;
  endfunction

  // Sine or cosine of d degrees (pi taken as 3.142) in Q1.TRIG_FRAC_BITS,
  // from a Q32 Taylor series, rounded half away from zero.
  function automatic trig_t trig_value(input int d, input bit want_cos);
    longint one;
    longint k;
    longint den;
    longint term;
    longint sum;
    longint n;
    longint m;
    longint r;
    bit     neg;
    one  = longint'(1) << 32;
    k    = longint'(d) * TRIG_K_STEP;
    den  = TRIG_DEN;
    term = want_cos ? one : udiv_trunc(k * one, den);
    sum  = term;
    n    = want_cos ? 0 : 1;
    for (int i = 0; i < SERIES_TERMS; i++) begin
      term = udiv_trunc(term * k, den * (n + 1));
      term = udiv_trunc(term * k, den * (n + 2));
      n    = n + 2;
      if ((i & 1) == 0) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    neg = (sum < 0);
    m   = neg ? -sum : sum;
    r   = (m + (longint'(1) << (31 - TRIG_FRAC_BITS))) >>> (32 - TRIG_FRAC_BITS);
    return trig_t'(neg ? -r : r);
  endfunction

  function automatic trig_table_t build_trig_table(input bit want_cos);
    trig_table_t tbl;
    for (int d = 0; d < FULL_TURN; d++) begin
      tbl[d] = trig_value(d, want_cos);
    end
    return tbl;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/prst_trig_rom.sv
// Sine and cosine lookup ROM with registered read, angle reduced modulo a full turn.
// Depends on prst_pkg for the table builder and types.
`default_nettype none

module prst_trig_rom
  import prst_pkg::*;
(
  input  logic   clk,
  input  logic   en,
  input  angle_t angle,
  output trig_t  sin_val,
  output trig_t  cos_val
);

  localparam int IDX_BITS = $clog2(FULL_TURN);
  localparam trig_table_t SIN_TABLE = build_trig_table(1'b0);
  localparam trig_table_t COS_TABLE = build_trig_table(1'b1);

  logic [IDX_BITS-1:0] idx;

  // The angle field is narrower than two turns, so one subtract reduces it.
  always_comb begin
    if (angle >= ANGLE_BITS'(FULL_TURN)) begin
      idx = IDX_BITS'(angle - ANGLE_BITS'(FULL_TURN));
    end else begin
      idx = IDX_BITS'(angle);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sin_val <= SIN_TABLE[idx];
      cos_val <= COS_TABLE[idx];
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/prst_xform_alu.sv
// Combinational transform datapath: load, translate, rotate and scale of the
// current point, with truncation toward zero and saturation. Depends on prst_pkg.
`default_nettype none

module prst_xform_alu
  import prst_pkg::*;
(
  input  xform_op_t op,
  input  trig_t     sin_val,
  input  trig_t     cos_val,
  input  coord_t    cur_x,
  input  coord_t    cur_y,
  input  coord_t    rot_cx,
  input  coord_t    rot_cy,
  output coord_t    new_x,
  output coord_t    new_y
);

  localparam int DIFF_W     = COORD_BITS + 1;
  localparam int ROT_PROD_W = DIFF_W + TRIG_BITS;
  localparam int ROT_SUM_W  = ROT_PROD_W + 2;
  localparam int SC_PROD_W  = DIFF_W + SCALE_BITS;
  localparam int SC_SUM_W   = SC_PROD_W + 1;
  localparam int SAT_IN_W   = (ROT_SUM_W > SC_SUM_W) ? ROT_SUM_W : SC_SUM_W;

  localparam logic signed [ROT_SUM_W-1:0] ROT_BIAS =
    ROT_SUM_W'((longint'(1) << TRIG_FRAC_BITS) - 1);
  localparam logic signed [SC_SUM_W-1:0] SC_BIAS =
    SC_SUM_W'((longint'(1) << SCALE_FRAC_BITS) - 1);

  function automatic coord_t sat_coord(input logic signed [SAT_IN_W-1:0] v);
    coord_t res;
    if (v[SAT_IN_W-1:COORD_BITS-1] == '0 || v[SAT_IN_W-1:COORD_BITS-1] == '1) begin
      res = v[COORD_BITS-1:0];
    end else if (v[SAT_IN_W-1]) begin
      res = {1'b1, {(COORD_BITS-1){1'b0}}};
    end else begin
      res = {1'b0, {(COORD_BITS-1){1'b1}}};
    end
    return res;
  endfunction

  coord_t arg_x;
  coord_t arg_y;
  coord_t ctr_x;
  coord_t ctr_y;
  scale_t scale;

  assign arg_x = op.arg_x;
  assign arg_y = op.arg_y;
  assign ctr_x = op.ctr_x;
  assign ctr_y = op.ctr_y;
  assign scale = op.scale;

  // Translate.
  logic signed [DIFF_W-1:0] tr_x;
  logic signed [DIFF_W-1:0] tr_y;
  assign tr_x = DIFF_W'(cur_x) + DIFF_W'(arg_x);
  assign tr_y = DIFF_W'(cur_y) + DIFF_W'(arg_y);

  // Rotate about the configured center.
  logic signed [DIFF_W-1:0]     rot_dx;
  logic signed [DIFF_W-1:0]     rot_dy;
  logic signed [ROT_PROD_W-1:0] rot_xc;
  logic signed [ROT_PROD_W-1:0] rot_xs;
  logic signed [ROT_PROD_W-1:0] rot_yc;
  logic signed [ROT_PROD_W-1:0] rot_ys;
  logic signed [ROT_SUM_W-1:0]  rot_sum_x;
  logic signed [ROT_SUM_W-1:0]  rot_sum_y;
  logic signed [ROT_SUM_W-1:0]  rot_adj_x;
  logic signed [ROT_SUM_W-1:0]  rot_adj_y;
  logic signed [ROT_SUM_W-1:0]  rot_q_x;
  logic signed [ROT_SUM_W-1:0]  rot_q_y;

  assign rot_dx = DIFF_W'(cur_x) - DIFF_W'(rot_cx);
  assign rot_dy = DIFF_W'(cur_y) - DIFF_W'(rot_cy);
  assign rot_xc = ROT_PROD_W'(rot_dx) * ROT_PROD_W'(cos_val);
  assign rot_xs = ROT_PROD_W'(rot_dx) * ROT_PROD_W'(sin_val);
  assign rot_yc = ROT_PROD_W'(rot_dy) * ROT_PROD_W'(cos_val);
  assign rot_ys = ROT_PROD_W'(rot_dy) * ROT_PROD_W'(sin_val);
  assign rot_sum_x = ROT_SUM_W'(rot_xc) - ROT_SUM_W'(rot_ys)
                   + (ROT_SUM_W'(rot_cx) <<< TRIG_FRAC_BITS);
  assign rot_sum_y = ROT_SUM_W'(rot_xs) + ROT_SUM_W'(rot_yc)
                   + (ROT_SUM_W'(rot_cy) <<< TRIG_FRAC_BITS);
  // Adding the bias to negative sums makes the arithmetic shift round toward zero.
  assign rot_adj_x = rot_sum_x + (rot_sum_x[ROT_SUM_W-1] ? ROT_BIAS : '0);
  assign rot_adj_y = rot_sum_y + (rot_sum_y[ROT_SUM_W-1] ? ROT_BIAS : '0);
  assign rot_q_x   = rot_adj_x >>> TRIG_FRAC_BITS;
  assign rot_q_y   = rot_adj_y >>> TRIG_FRAC_BITS;

  // Scale about the center chosen in the input stage.
  logic signed [DIFF_W-1:0]    sc_dx;
  logic signed [DIFF_W-1:0]    sc_dy;
  logic signed [SC_PROD_W-1:0] sc_px;
  logic signed [SC_PROD_W-1:0] sc_py;
  logic signed [SC_SUM_W-1:0]  sc_sum_x;
  logic signed [SC_SUM_W-1:0]  sc_sum_y;
  logic signed [SC_SUM_W-1:0]  sc_adj_x;
  logic signed [SC_SUM_W-1:0]  sc_adj_y;
  logic signed [SC_SUM_W-1:0]  sc_q_x;
  logic signed [SC_SUM_W-1:0]  sc_q_y;

  assign sc_dx    = DIFF_W'(cur_x) - DIFF_W'(ctr_x);
  assign sc_dy    = DIFF_W'(cur_y) - DIFF_W'(ctr_y);
  assign sc_px    = SC_PROD_W'(scale) * SC_PROD_W'(sc_dx);
  assign sc_py    = SC_PROD_W'(scale) * SC_PROD_W'(sc_dy);
  assign sc_sum_x = SC_SUM_W'(sc_px) + (SC_SUM_W'(ctr_x) <<< SCALE_FRAC_BITS);
  assign sc_sum_y = SC_SUM_W'(sc_py) + (SC_SUM_W'(ctr_y) <<< SCALE_FRAC_BITS);
  assign sc_adj_x = sc_sum_x + (sc_sum_x[SC_SUM_W-1] ? SC_BIAS : '0);
  assign sc_adj_y = sc_sum_y + (sc_sum_y[SC_SUM_W-1] ? SC_BIAS : '0);
  assign sc_q_x   = sc_adj_x >>> SCALE_FRAC_BITS;
  assign sc_q_y   = sc_adj_y >>> SCALE_FRAC_BITS;

  always_comb begin
    unique case (op.action)
      ACT_LOAD: begin
        new_x = arg_x;
        new_y = arg_y;
      end
      ACT_TRANSLATE: begin
        new_x = sat_coord(SAT_IN_W'(tr_x));
        new_y = sat_coord(SAT_IN_W'(tr_y));
      end
      ACT_ROTATE: begin
        new_x = sat_coord(SAT_IN_W'(rot_q_x));
        new_y = sat_coord(SAT_IN_W'(rot_q_y));
      end
      ACT_SCALE_RECT, ACT_SCALE_PIVOT: begin
        new_x = sat_coord(SAT_IN_W'(sc_q_x));
        new_y = sat_coord(SAT_IN_W'(sc_q_y));
      end
      default: begin
        new_x = cur_x;
        new_y = cur_y;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/core/point_rotate_scale_translate.sv
// An accepted request passes the input register, then the result register.
// Throughput: one request per cycle while m_tready is high; the point register
// feeds back through a multiplier, adds and saturation in the datapath each cycle.
// Reset (synchronous, active high) clears both valid flags, sets the point to (0, 0)
// and the rotation center to (375, 210). There is no clearing pass.
`default_nettype none

`include "point_rotate_scale_translate_defines.svh"

module point_rotate_scale_translate
  import prst_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [COORD_BITS-1:0]     cfg_data,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  // arg_x, arg_y, angle_deg, scale_q8, rect_left, rect_top, rect_right, rect_bottom
  input  logic [S_DATA_BITS-1:0]    s_tdata,
  // action
  input  logic [ACTION_BITS-1:0]    s_tuser,
  output logic                      m_tvalid,
  input  logic                      m_tready,
  // out_x, out_y
  output logic [M_DATA_BITS-1:0]    m_tdata
);

  coord_t rot_cx;
  coord_t rot_cy;

  always_ff @(posedge clk) begin
    if (rst) begin
      rot_cx <= ROT_CX_RESET;
      rot_cy <= ROT_CY_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ROT_CX: rot_cx <= coord_t'(cfg_data);
        CFG_ROT_CY: rot_cy <= coord_t'(cfg_data);
        default: begin
        end
      endcase
    end
  end

  // Input field unpacking.
  coord_t in_arg_x;
  coord_t in_arg_y;
  angle_t in_angle;
  scale_t in_scale;
  coord_t in_left;
  coord_t in_top;
  coord_t in_right;
  coord_t in_bottom;

  assign in_arg_x  = s_tdata[ARG_X_LSB +: COORD_BITS];
  assign in_arg_y  = s_tdata[ARG_Y_LSB +: COORD_BITS];
  assign in_angle  = s_tdata[ANGLE_LSB +: ANGLE_BITS];
  assign in_scale  = s_tdata[SCALE_LSB +: SCALE_BITS];
  assign in_left   = s_tdata[LEFT_LSB +: COORD_BITS];
  assign in_top    = s_tdata[TOP_LSB +: COORD_BITS];
  assign in_right  = s_tdata[RIGHT_LSB +: COORD_BITS];
  assign in_bottom = s_tdata[BOTTOM_LSB +: COORD_BITS];

  // Rectangle midpoint, truncated toward zero: bump negative sums before the halving.
  logic signed [COORD_BITS:0] rect_sum_x;
  logic signed [COORD_BITS:0] rect_sum_y;
  logic        [COORD_BITS:0] rect_adj_x;
  logic        [COORD_BITS:0] rect_adj_y;
  action_t   in_action;
  xform_op_t in_op;

  assign rect_sum_x = (COORD_BITS+1)'(in_left) + (COORD_BITS+1)'(in_right);
  assign rect_sum_y = (COORD_BITS+1)'(in_top) + (COORD_BITS+1)'(in_bottom);
  assign rect_adj_x = rect_sum_x + (COORD_BITS+1)'(rect_sum_x[COORD_BITS]);
  assign rect_adj_y = rect_sum_y + (COORD_BITS+1)'(rect_sum_y[COORD_BITS]);
  assign in_action  = action_t'(s_tuser);

  always_comb begin
    in_op.action = in_action;
    in_op.arg_x  = in_arg_x;
    in_op.arg_y  = in_arg_y;
    in_op.scale  = in_scale;
    if (in_action == ACT_SCALE_RECT) begin
      in_op.ctr_x = rect_adj_x[COORD_BITS:1];
      in_op.ctr_y = rect_adj_y[COORD_BITS:1];
    end else begin
      in_op.ctr_x = in_arg_x;
      in_op.ctr_y = in_arg_y;
    end
  end

  // Input register stage.
  logic      s_accept;
  logic      pipe_valid;
  logic      advance;
  xform_op_t op_q;
  trig_t     sin_q;
  trig_t     cos_q;

  assign advance  = pipe_valid && (!m_tvalid || m_tready);
  assign s_tready = !pipe_valid || advance;
  assign s_accept = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pipe_valid <= 1'b0;
    end else if (s_accept) begin
      pipe_valid <= 1'b1;
    end else if (advance) begin
      pipe_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      op_q <= in_op;
    end
  end

  prst_trig_rom u_trig_rom (
    .clk     (clk),
    .en      (s_accept),
    .angle   (in_angle),
    .sin_val (sin_q),
    .cos_val (cos_q)
  );

  // The result register is also the current point.
  coord_t out_x;
  coord_t out_y;
  coord_t new_x;
  coord_t new_y;

  prst_xform_alu u_xform_alu (
    .op      (op_q),
    .sin_val (sin_q),
    .cos_val (cos_q),
    .cur_x   (out_x),
    .cur_y   (out_y),
    .rot_cx  (rot_cx),
    .rot_cy  (rot_cy),
    .new_x   (new_x),
    .new_y   (new_y)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      out_x    <= '0;
      out_y    <= '0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
      out_x    <= new_x;
      out_y    <= new_y;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  assign m_tdata = M_DATA_BITS'({out_y, out_x});

  `PRST_ASSERT_NEXT(a_advance_gives_result, advance, m_tvalid)
  `PRST_ASSERT_NEXT(a_load_sets_point, advance && op_q.action == ACT_LOAD,
                    out_x == $past(op_q.arg_x) && out_y == $past(op_q.arg_y))
  `PRST_ASSERT_NEXT(a_point_holds_when_idle, !advance, $stable(out_x) && $stable(out_y))
  `PRST_ASSERT_IMPL(a_stall_only_when_full, !s_tready, pipe_valid && m_tvalid && !m_tready)

endmodule

`default_nettype wire
